FILE: src/scsph_pkg.sv
package scsph_pkg;

    // Kind of work handed from the front end to the back end
    typedef enum logic [0:0] {
        OP_TABLE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // Classified item as it travels through the command queue
    typedef struct packed {
        op_t         op;
        logic        wr;      // store write is in range
        logic        emit;    // sample closes the vector
        logic [3:0]  sph;
        logic [3:0]  slot;
        logic [4:0]  col;
        logic [31:0] data;    // coefficient or sample
        logic [4:0]  cnt;     // already clamped to the row length
        logic [4:0]  sidx;
        logic [15:0] vec;
    } cmd_t;

    // One spherical result
    typedef struct packed {
        logic [3:0]  sph;
        logic [15:0] vec;
        logic [63:0] value;
        logic        last;
    } result_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_TAB,
        ST_COL,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

    localparam logic [4:0] NUM_SPH_RESET = 5'd1;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    // Signed 64-bit add clamped to the representable range
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
        begin
            s = SAT_MAX;
        end
        else if (a[63] && b[63] && !s[63])
        begin
            s = SAT_MIN;
        end
        return s;
    endfunction

endpackage

FILE: src/scsph_ram.sv
module scsph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/scsph_fifo.sv
module scsph_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: src/scsph_front.sv
module scsph_front #(
    parameter int MAX_CART              = 32,
    parameter int MAX_SPH               = 16,
    parameter int ENTRIES_PER_COMPONENT = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [3:0]         sph_index,
    input  logic [3:0]         slot,
    input  logic [4:0]         cart_col,
    input  logic signed [31:0] coef,
    input  logic [4:0]         entry_count,
    input  logic [4:0]         sample_index,
    input  logic signed [31:0] sample,
    input  logic [15:0]        vector_index,
    input  logic               last,
    input  logic               cmd_pop,
    output logic               cmd_empty,
    output scsph_pkg::cmd_t    cmd
);

    localparam int CMD_W = $bits(scsph_pkg::cmd_t);

    scsph_pkg::cmd_t   cmd_in;
    logic [CMD_W-1:0]  cmd_q;
    logic              is_table;
    logic              tab_ok;
    logic              samp_ok;
    logic              keep;
    logic [4:0]        cnt_clamped;

    // Range checks and classification
    always_comb
    begin
        is_table    = (req_type == scsph_pkg::OP_TABLE);
        tab_ok      = (32'(sph_index) < 32'(MAX_SPH)) &&
                      (32'(slot) < 32'(ENTRIES_PER_COMPONENT));
        samp_ok     = (32'(sample_index) < 32'(MAX_CART));
        cnt_clamped = (32'(entry_count) > 32'(ENTRIES_PER_COMPONENT)) ?
                      5'(ENTRIES_PER_COMPONENT) : entry_count;

        cmd_in.op   = is_table ? scsph_pkg::OP_TABLE : scsph_pkg::OP_SAMPLE;
        cmd_in.wr   = is_table ? tab_ok : samp_ok;
        cmd_in.emit = !is_table && last;
        cmd_in.sph  = sph_index;
        cmd_in.slot = slot;
        cmd_in.col  = cart_col;
        cmd_in.data = is_table ? coef : sample;
        cmd_in.cnt  = cnt_clamped;
        cmd_in.sidx = sample_index;
        cmd_in.vec  = vector_index;

        // items with no effect are dropped here
        keep        = cmd_in.wr || cmd_in.emit;
    end

    // Command queue towards the back end
    scsph_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_q),
        .empty   (cmd_empty)
    );

    assign cmd = scsph_pkg::cmd_t'(cmd_q);

endmodule

FILE: src/scsph_back.sv
module scsph_back #(
    parameter int MAX_CART              = 32,
    parameter int MAX_SPH               = 16,
    parameter int ENTRIES_PER_COMPONENT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_wdata,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    input  scsph_pkg::cmd_t     cmd,
    input  logic                res_full,
    output logic                res_push,
    output scsph_pkg::result_t  res_data
);

    localparam int TAB_DEPTH = MAX_SPH * ENTRIES_PER_COMPONENT;
    localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int SAMP_AW   = (MAX_CART > 1) ? $clog2(MAX_CART) : 1;
    localparam int SPH_AW    = (MAX_SPH > 1) ? $clog2(MAX_SPH) : 1;
    localparam int CNT_W     = $clog2(ENTRIES_PER_COMPONENT + 1);
    localparam int N_W       = $clog2(MAX_SPH + 1);
    localparam int TAB_W     = 37;

    scsph_pkg::state_t   state_reg;
    scsph_pkg::state_t   state_next;
    logic [4:0]          num_sph_reg;
    logic [CNT_W-1:0]    count_reg [MAX_SPH];
    logic [N_W-1:0]      n_reg;
    logic [N_W-1:0]      r_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [CNT_W-1:0]    i_reg;
    logic [15:0]         vec_reg;
    logic signed [31:0]  coef_reg;
    logic                col_ok_reg;
    logic signed [63:0]  prod_reg;
    logic [63:0]         acc_reg;

    logic                tab_we;
    logic [TAB_AW-1:0]   tab_waddr;
    logic [TAB_AW-1:0]   tab_raddr;
    logic [TAB_W-1:0]    tab_rdata;
    logic                samp_we;
    logic [SAMP_AW-1:0]  samp_waddr;
    logic [SAMP_AW-1:0]  samp_raddr;
    logic [31:0]         samp_rdata;
    logic [N_W-1:0]      n_calc;
    logic [CNT_W-1:0]    k_cur;
    logic                r_last;
    logic                i_last;
    logic [4:0]          tab_col;

    // Store access decode
    always_comb
    begin
        tab_we     = cmd_pop && (cmd.op == scsph_pkg::OP_TABLE) && cmd.wr;
        tab_waddr  = TAB_AW'(32'(cmd.sph) * ENTRIES_PER_COMPONENT + 32'(cmd.slot));
        samp_we    = cmd_pop && (cmd.op == scsph_pkg::OP_SAMPLE) && cmd.wr;
        samp_waddr = SAMP_AW'(cmd.sidx);
        tab_raddr  = TAB_AW'(32'(r_reg) * ENTRIES_PER_COMPONENT + 32'(i_reg));
        tab_col    = tab_rdata[36:32];
        samp_raddr = SAMP_AW'(tab_col);
        n_calc     = (32'(num_sph_reg) > 32'(MAX_SPH)) ? N_W'(MAX_SPH) : N_W'(num_sph_reg);
        k_cur      = count_reg[SPH_AW'(r_reg)];
        r_last     = ((r_reg + N_W'(1)) == n_reg);
        i_last     = ((i_reg + CNT_W'(1)) == k_reg);
    end

    // Coefficient and column table, one row per component
    scsph_ram #(
        .WIDTH (TAB_W),
        .DEPTH (TAB_DEPTH)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata ({cmd.col, cmd.data}),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // Cartesian sample store
    scsph_ram #(
        .WIDTH (32),
        .DEPTH (MAX_CART)
    ) u_samp_ram (
        .clk   (clk),
        .we    (samp_we),
        .waddr (samp_waddr),
        .wdata (cmd.data),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scsph_pkg::ST_IDLE:
            begin
                if (!cmd_empty && cmd.emit && (n_calc != '0))
                begin
                    state_next = scsph_pkg::ST_COMP;
                end
            end
            scsph_pkg::ST_COMP:
            begin
                state_next = (k_cur == '0) ? scsph_pkg::ST_EMIT : scsph_pkg::ST_TAB;
            end
            scsph_pkg::ST_TAB:
            begin
                state_next = scsph_pkg::ST_COL;
            end
            scsph_pkg::ST_COL:
            begin
                state_next = scsph_pkg::ST_MUL;
            end
            scsph_pkg::ST_MUL:
            begin
                state_next = scsph_pkg::ST_ACC;
            end
            scsph_pkg::ST_ACC:
            begin
                state_next = i_last ? scsph_pkg::ST_EMIT : scsph_pkg::ST_TAB;
            end
            scsph_pkg::ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = r_last ? scsph_pkg::ST_IDLE : scsph_pkg::ST_COMP;
                end
            end
            default:
            begin
                state_next = scsph_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        cmd_pop        = (state_reg == scsph_pkg::ST_IDLE) && !cmd_empty;
        res_push       = (state_reg == scsph_pkg::ST_EMIT) && !res_full;
        res_data.sph   = 4'(r_reg);
        res_data.vec   = vec_reg;
        res_data.value = acc_reg;
        res_data.last  = r_last;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= scsph_pkg::ST_IDLE;
            num_sph_reg <= scsph_pkg::NUM_SPH_RESET;
            n_reg       <= '0;
            r_reg       <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            for (int s = 0; s < MAX_SPH; s++)
            begin
                count_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                num_sph_reg <= cfg_wdata;
            end
            if (tab_we)
            begin
                count_reg[SPH_AW'(cmd.sph)] <= CNT_W'(cmd.cnt);
            end
            case (state_reg)
                scsph_pkg::ST_IDLE:
                begin
                    if (cmd_pop && cmd.emit)
                    begin
                        n_reg <= n_calc;
                        r_reg <= '0;
                    end
                end
                scsph_pkg::ST_COMP:
                begin
                    k_reg <= k_cur;
                    i_reg <= '0;
                end
                scsph_pkg::ST_ACC:
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
                scsph_pkg::ST_EMIT:
                begin
                    if (!res_full)
                    begin
                        r_reg <= r_reg + N_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Multiply-accumulate datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            scsph_pkg::ST_IDLE:
            begin
                if (cmd_pop && cmd.emit)
                begin
                    vec_reg <= cmd.vec;
                end
            end
            scsph_pkg::ST_COMP:
            begin
                acc_reg <= '0;
            end
            scsph_pkg::ST_COL:
            begin
                coef_reg   <= $signed(tab_rdata[31:0]);
                col_ok_reg <= (32'(tab_col) < 32'(MAX_CART));
            end
            scsph_pkg::ST_MUL:
            begin
                prod_reg <= col_ok_reg ? (coef_reg * $signed(samp_rdata)) : 64'sd0;
            end
            scsph_pkg::ST_ACC:
            begin
                acc_reg <= scsph_pkg::sat_add(acc_reg, prod_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: src/sparse_cartesian_to_spherical_transform_unit.sv
// Sparse cartesian-to-spherical transform.
// Input channel (push/full): an item is taken on a clock edge with push high
// and full low. req_type 0 loads one table entry (component, slot, column,
// Q3.28 coefficient, used-slot count); req_type 1 stores a Q7.24 sample.
// A sample with last set emits num_spherical results, capped at MAX_SPH.
// Result channel (empty/pop): the oldest result sits on the ports while
// empty is low and leaves on an edge with pop high. Results carry the
// component, the echoed vector index, the saturated 64-bit sum with 52
// fraction bits, and last_out on the final component.
// Config: cfg_we writes cfg_wdata into num_spherical (reset value 1).
// Structure: a two-entry command queue feeds a sequencer with one shared MAC.
// Table and sample items are each taken by the back end in its idle state. For
// a closing sample, each component runs a setup state, then per used slot a
// table read, sample read, multiply and accumulate state, then an emit state
// that waits while the result queue is full.
// Reset clears the queues, the slot counts and the register; the tables
// hold no reset value. A stalled receiver fills the two-entry result queue,
// then the sequencer waits and the command queue backs up into full.
module sparse_cartesian_to_spherical_transform_unit #(
    parameter int MAX_CART              = 32,
    parameter int MAX_SPH               = 16,
    parameter int ENTRIES_PER_COMPONENT = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [3:0]         sph_index,
    input  logic [3:0]         slot,
    input  logic [4:0]         cart_col,
    input  logic signed [31:0] coef,
    input  logic [4:0]         entry_count,
    input  logic [4:0]         sample_index,
    input  logic signed [31:0] sample,
    input  logic [15:0]        vector_index,
    input  logic               last,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         sph_index_out,
    output logic [15:0]        vector_out,
    output logic signed [63:0] value,
    output logic               last_out,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata
);

    localparam int RES_W = $bits(scsph_pkg::result_t);

    scsph_pkg::cmd_t     cmd;
    logic                cmd_empty;
    logic                cmd_pop;
    scsph_pkg::result_t  res_in;
    scsph_pkg::result_t  res_out;
    logic [RES_W-1:0]    res_q;
    logic                res_push;
    logic                res_full;

    // Front end: accept and classify
    scsph_front #(
        .MAX_CART              (MAX_CART),
        .MAX_SPH               (MAX_SPH),
        .ENTRIES_PER_COMPONENT (ENTRIES_PER_COMPONENT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .sph_index    (sph_index),
        .slot         (slot),
        .cart_col     (cart_col),
        .coef         (coef),
        .entry_count  (entry_count),
        .sample_index (sample_index),
        .sample       (sample),
        .vector_index (vector_index),
        .last         (last),
        .cmd_pop      (cmd_pop),
        .cmd_empty    (cmd_empty),
        .cmd          (cmd)
    );

    // Back end: stores and MAC sequencer
    scsph_back #(
        .MAX_CART              (MAX_CART),
        .MAX_SPH               (MAX_SPH),
        .ENTRIES_PER_COMPONENT (ENTRIES_PER_COMPONENT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    // Result queue towards the receiver
    scsph_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

    assign res_out       = scsph_pkg::result_t'(res_q);
    assign sph_index_out = res_out.sph;
    assign vector_out    = res_out.vec;
    assign value         = $signed(res_out.value);
    assign last_out      = res_out.last;

endmodule

FILE: src/scsph_checker.sv
module scsph_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  sph_index_out,
    input logic [15:0] vector_out,
    input logic [63:0] value,
    input logic        last_out
);

    logic [3:0]  exp_sph_reg;
    logic [15:0] run_vec_reg;

    // Track where the next result of a run must stand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_sph_reg <= '0;
            run_vec_reg <= '0;
        end
        else if (pop && !empty)
        begin
            exp_sph_reg <= last_out ? 4'd0 : sph_index_out + 4'd1;
            run_vec_reg <= vector_out;
        end
    end

    // Nothing waits on the result side while in reset
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // Components of a run come out in order, starting from zero
    a_sph_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sph_index_out == exp_sph_reg))
        else $error("component out of order");

    // All results of one run carry the same vector index
    a_vec_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (exp_sph_reg != 4'd0)) |-> (vector_out == run_vec_reg))
        else $error("vector index changed within a run");

    // A waiting result holds until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value) && $stable(last_out)))
        else $error("waiting result changed");

endmodule

bind sparse_cartesian_to_spherical_transform_unit scsph_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .sph_index_out (sph_index_out),
    .vector_out    (vector_out),
    .value         (value),
    .last_out      (last_out)
);
